// ===== sv/sefp_pkg.sv =====
// shared types and constants of the stx/etx command frame parser
package sefp_pkg;

    localparam int CMD_LEN_DEF  = 3;
    localparam int DATA_MAX_DEF = 16;
    localparam int FIFO_DEPTH   = 2;
    localparam int BURST_LEN    = 4;
    localparam int CFG_IDX_W    = 2;

    localparam logic [7:0] START_RST  = 8'd2;
    localparam logic [7:0] END_RST    = 8'd3;
    localparam logic [7:0] REPLY_RST  = 8'd0;

    localparam logic [7:0] CMD_TAG    = 8'h43;  // ascii 'C'
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] DEC_BASE   = 8'd10;

    localparam logic [7:0] CMD_LED_ON  = 8'd1;
    localparam logic [7:0] CMD_LED_OFF = 8'd2;
    localparam logic [7:0] CMD_DUMP    = 8'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CMD,
        PH_DATA
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_START,
        EV_ABORT,
        EV_DONE,
        EV_REJECT
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START,
        REG_END,
        REG_REPLY
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] reply_byte;
    } t_cfg;

    // one queued job: a single result, or a burst of data bytes
    typedef struct packed {
        logic                      burst;
        logic [7:0]                tx_byte;
        logic                      tx_valid;
        logic                      led_on;
        t_event                    ev;
        logic [BURST_LEN-1:0][7:0] data;
    } t_job;

endpackage

// ===== sv/sefp_front.sv =====
// front end: frame tracking, command decode and job generation
module sefp_front
    import sefp_pkg::*;
#(
    parameter int CMD_LEN  = CMD_LEN_DEF,
    parameter int DATA_MAX = DATA_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    localparam int POS_MAX = (CMD_LEN > DATA_MAX) ? CMD_LEN : DATA_MAX;
    localparam int POS_W   = $clog2(POS_MAX + 1);
    localparam int CIDX_W  = $clog2(CMD_LEN);
    localparam int DIDX_W  = $clog2(DATA_MAX);

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_cmd  [CMD_LEN];
    logic [7:0]       r_data [DATA_MAX];
    logic             r_led, n_led;

    logic             accept;
    logic             is_start, is_end, in_range, cmd_done;
    logic             frame_end, abort, cmd_we, data_we, tag_ok;
    logic [POS_W-1:0] pos_inc;
    logic [7:0]       dig1, dig2, cmd_num;
    logic [7:0]       tens;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    assign is_start = (i_rx_byte == i_cfg.start_byte);
    assign is_end   = (i_rx_byte == i_cfg.end_byte);
    assign pos_inc  = r_pos + POS_W'(1);
    assign in_range = (r_pos < POS_W'(DATA_MAX));
    assign cmd_done = (pos_inc >= POS_W'(CMD_LEN));

    assign frame_end = !is_start && (r_phase == PH_DATA) && in_range && is_end;
    assign abort     = !is_start && (r_phase == PH_DATA) && !in_range;
    assign cmd_we    = !is_start && (r_phase == PH_CMD);
    assign data_we   = !is_start && (r_phase == PH_DATA) && in_range && !is_end;

    // two ascii digits, modulo 256
    assign tag_ok  = (r_cmd[0] == CMD_TAG);
    assign dig1    = r_cmd[1] - ASCII_ZERO;
    assign dig2    = r_cmd[2] - ASCII_ZERO;
    assign tens    = dig1 * DEC_BASE;
    assign cmd_num = tens + dig2;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        if (is_start) begin
            n_phase = PH_CMD;
            n_pos   = '0;
        end else begin
            case (r_phase)
                PH_CMD: begin
                    if (cmd_done) begin
                        n_phase = PH_DATA;
                        n_pos   = '0;
                    end else begin
                        n_pos = pos_inc;
                    end
                end
                PH_DATA: begin
                    if (!in_range || is_end) begin
                        n_phase = PH_IDLE;
                        n_pos   = '0;
                    end else begin
                        n_pos = pos_inc;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // job and led
    always_comb begin
        n_led          = r_led;
        o_job.burst    = 1'b0;
        o_job.tx_byte  = '0;
        o_job.tx_valid = 1'b0;
        o_job.ev       = EV_NONE;
        for (int k = 0; k < BURST_LEN; k++) begin
            o_job.data[k] = r_data[k];
        end
        if (is_start) begin
            o_job.ev = EV_START;
        end else if (abort) begin
            o_job.ev = EV_ABORT;
        end else if (frame_end) begin
            if (!tag_ok) begin
                o_job.ev = EV_REJECT;
            end else begin
                o_job.ev = EV_DONE;
                case (cmd_num)
                    CMD_LED_ON: begin
                        n_led          = 1'b1;
                        o_job.tx_byte  = i_cfg.reply_byte;
                        o_job.tx_valid = 1'b1;
                    end
                    CMD_LED_OFF: begin
                        n_led = 1'b0;
                    end
                    CMD_DUMP: begin
                        o_job.burst = 1'b1;
                    end
                    default: begin
                        n_led = r_led;
                    end
                endcase
            end
        end
        o_job.led_on = n_led;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_led   <= 1'b0;
            for (int k = 0; k < DATA_MAX; k++) begin
                r_data[k] <= '0;
            end
        end else if (accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_led   <= n_led;
            if (data_we) begin
                r_data[r_pos[DIDX_W-1:0]] <= i_rx_byte;
            end
        end
    end

    // command bytes are always written before a frame can read them
    always_ff @(posedge i_clk) begin
        if (accept && cmd_we) begin
            r_cmd[r_pos[CIDX_W-1:0]] <= i_rx_byte;
        end
    end

endmodule

// ===== sv/sefp_fifo.sv =====
// small job queue between front and back end
module sefp_fifo
    import sefp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_job             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== sv/sefp_back.sv =====
// back end: output register, expands dump jobs into byte bursts
module sefp_back
    import sefp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_tx_byte,
    output logic       o_tx_valid,
    output logic       o_led_on,
    output logic [2:0] o_event_res,
    output logic       o_last
);

    localparam int BEAT_W = $clog2(BURST_LEN);

    logic                      r_valid;
    logic                      r_last;
    logic [BEAT_W-1:0]         r_beat;
    logic [7:0]                r_tx;
    logic                      r_txv;
    logic                      r_led;
    t_event                    r_ev;
    logic [BURST_LEN-1:0][7:0] r_data;

    logic              taken, step;
    logic [BEAT_W-1:0] n_beat;

    assign taken  = r_valid && i_ready;
    assign step   = taken && !r_last;
    assign o_pop  = !i_empty && (!r_valid || (taken && r_last));
    assign n_beat = r_beat + BEAT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b1;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_last  <= !i_job.burst;
        end else if (step) begin
            r_last <= (n_beat == BEAT_W'(BURST_LEN - 1));
        end else if (taken) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_beat <= '0;
            r_tx   <= i_job.burst ? i_job.data[0] : i_job.tx_byte;
            r_txv  <= i_job.burst | i_job.tx_valid;
            r_led  <= i_job.led_on;
            r_ev   <= i_job.ev;
            r_data <= i_job.data;
        end else if (step) begin
            r_beat <= n_beat;
            r_tx   <= r_data[n_beat];
        end
    end

    assign o_valid     = r_valid;
    assign o_tx_byte   = r_tx;
    assign o_tx_valid  = r_txv;
    assign o_led_on    = r_led;
    assign o_event_res = r_ev;
    assign o_last      = r_last;

    // a non-final result only comes from a dump burst
    a_burst_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_tx_valid && (o_event_res == EV_DONE))
        else $error("non-final result outside a dump burst");

    // a burst never stops before its final byte
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid)
        else $error("burst dropped before final byte");

    // led state cannot change within a burst
    a_burst_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> $stable(o_led_on))
        else $error("led changed inside a burst");

endmodule

// ===== sv/stx_etx_command_frame_parser_top.sv =====
// top level of the stx/etx framed command parser
// Byte-stream command parser. A start byte (any phase) opens a frame, CMD_LEN
// command bytes follow, then data bytes up to DATA_MAX until the end byte.
// A closed frame starting with 'C' carries a two-digit decimal command:
// 1 sets the led and sends reply_byte, 2 clears the led, 3 sends data bytes
// zero to three as a four-result burst (o_last marks the final one). Every
// other byte gives one result with an event code. The front end takes one
// byte per clock while the two-entry job queue has room; the back end
// emits one result per clock from its output register while i_ready is
// high and jobs are queued. Config writes are taken every cycle
// (o_cfg_ready is tied high) and writes to an index past the register list
// are dropped. No clearing pass runs after reset.
module stx_etx_command_frame_parser_top
    import sefp_pkg::*;
#(
    parameter int CMD_LEN  = CMD_LEN_DEF,
    parameter int DATA_MAX = DATA_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    // received bytes
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_rx_byte,
    // results
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_tx_byte,
    output logic                 o_tx_valid,
    output logic                 o_led_on,
    output logic [2:0]           o_event_res,
    output logic                 o_last
);

    t_cfg r_cfg;
    t_job push_job, pop_job;
    logic push, pop, full, empty;

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte <= START_RST;
            r_cfg.end_byte   <= END_RST;
            r_cfg.reply_byte <= REPLY_RST;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_START: r_cfg.start_byte <= i_cfg_data;
                REG_END:   r_cfg.end_byte   <= i_cfg_data;
                REG_REPLY: r_cfg.reply_byte <= i_cfg_data;
                default:   r_cfg            <= r_cfg;
            endcase
        end
    end

    // front end: frame state and command decode
    sefp_front #(
        .CMD_LEN  (CMD_LEN),
        .DATA_MAX (DATA_MAX)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_full    (full),
        .o_push    (push),
        .o_job     (push_job)
    );

    // job queue decouples byte intake from result delivery
    sefp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    // back end: output register and burst expansion
    sefp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (pop_job),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_tx_byte   (o_tx_byte),
        .o_tx_valid  (o_tx_valid),
        .o_led_on    (o_led_on),
        .o_event_res (o_event_res),
        .o_last      (o_last)
    );

endmodule

// ===== sim/tb_stx_etx_command_frame_parser_top.sv =====
// self-checking testbench for the stx/etx command frame parser top level
`timescale 1ns / 1ps

module tb_stx_etx_command_frame_parser_top;
    import sefp_pkg::*;

    // index beyond the register list, the block drops such writes
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // one result item as seen on the output port
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       led_on;
        t_event     ev;
        logic       last;
    } t_parser_out;

    // one directed row, the expected fields count only when typed is set
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic [7:0] tx;
        logic       txv;
        logic       led;
        t_event     ev;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [7:0]           i_rx_byte;
    logic                 o_valid;
    logic                 i_ready;
    logic [7:0]           o_tx_byte;
    logic                 o_tx_valid;
    logic                 o_led_on;
    logic [2:0]           o_event_res;
    logic                 o_last;

    // predictor copy of the registers and the parser state
    logic [7:0] cfg_start;
    logic [7:0] cfg_end;
    logic [7:0] cfg_reply;
    t_phase     p_phase;
    logic [4:0] p_pos;
    logic [7:0] p_cmd [CMD_LEN_DEF];
    logic [7:0] p_data [DATA_MAX_DEF];
    logic       p_led;

    t_parser_out step_out [BURST_LEN];
    t_parser_out parser_out_q [$];

    int rx_sent      = 0;
    int rx_gap       = 0;
    bit calm_gap     = 1'b0;
    int mismatch_cnt = 0;

    stx_etx_command_frame_parser_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_tx_byte   (o_tx_byte),
        .o_tx_valid  (o_tx_valid),
        .o_led_on    (o_led_on),
        .o_event_res (o_event_res),
        .o_last      (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // advance the parser state by one byte, results land in step_out
    function automatic int parse_rx_byte(input logic [7:0] b);
        t_event     ev;
        logic [7:0] txb;
        logic       txv;
        logic       dump;
        logic [7:0] num;
        int         k;
        ev   = EV_NONE;
        txb  = 8'h00;
        txv  = 1'b0;
        dump = 1'b0;
        if (b == cfg_start) begin
            // start byte restarts in any phase, even when it equals the end byte
            p_phase = PH_CMD;
            p_pos   = '0;
            ev      = EV_START;
        end else if (p_phase == PH_CMD) begin
            p_cmd[p_pos] = b;
            p_pos++;
            if (p_pos >= CMD_LEN_DEF) begin
                p_phase = PH_DATA;
                p_pos   = '0;
            end
        end else if (p_phase == PH_DATA) begin
            if (p_pos >= DATA_MAX_DEF) begin
                // data store full, any byte but start aborts
                p_phase = PH_IDLE;
                p_pos   = '0;
                ev      = EV_ABORT;
            end else if (b != cfg_end) begin
                p_data[p_pos] = b;
                p_pos++;
            end else begin
                p_phase = PH_IDLE;
                p_pos   = '0;
                if (p_cmd[0] != CMD_TAG) begin
                    ev = EV_REJECT;
                end else begin
                    ev  = EV_DONE;
                    num = (p_cmd[1] - ASCII_ZERO) * DEC_BASE + (p_cmd[2] - ASCII_ZERO);
                    if (num == CMD_LED_ON) begin
                        p_led = 1'b1;
                        txb   = cfg_reply;
                        txv   = 1'b1;
                    end else if (num == CMD_LED_OFF) begin
                        p_led = 1'b0;
                    end else if (num == CMD_DUMP) begin
                        dump = 1'b1;
                    end
                end
            end
        end
        if (dump) begin
            for (k = 0; k < BURST_LEN; k++)
                step_out[k] = '{p_data[k], 1'b1, p_led, EV_DONE, k == BURST_LEN - 1};
            return BURST_LEN;
        end
        step_out[0] = '{txb, txv, p_led, ev, 1'b1};
        return 1;
    endfunction

    // random byte that neither opens nor closes a frame
    function automatic logic [7:0] pick_payload_byte();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == cfg_start || v == cfg_end);
        return v;
    endfunction

    function automatic void cmp_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            mismatch_cnt++;
        end
    endfunction

    // offer one byte, predict its results once accepted, pick the next gap
    task automatic send_rx(input logic [7:0] b, input bit typed = 1'b0,
                           input t_parser_out typed_out = '0);
        int n;
        int k;
        int r;
        repeat (rx_gap) @(posedge i_clk);
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        n = parse_rx_byte(b);
        if (typed)
            parser_out_q.push_back(typed_out);
        else
            for (k = 0; k < n; k++) parser_out_q.push_back(step_out[k]);
        rx_sent++;
        r = $urandom_range(0, 99);
        if (calm_gap || r < 50) rx_gap = 0;
        else if (r < 85) rx_gap = $urandom_range(1, 3);
        else if (r < 97) rx_gap = $urandom_range(4, 10);
        else rx_gap = $urandom_range(20, 60);
        // valid stays up when the next byte follows at once
        if (rx_gap != 0) i_valid <= 1'b0;
    endtask

    // hold the byte channel until every pending result has come out
    task automatic pause_rx();
        if (rx_gap == 0) i_valid <= 1'b0;
        do @(posedge i_clk); while (parser_out_q.size() != 0);
        rx_gap = 0;
    endtask

    // write the three registers back to back, optionally one dropped index too
    task automatic program_cfg(input logic [7:0] s, input logic [7:0] e,
                               input logic [7:0] r, input bit junk);
        logic [CFG_IDX_W-1:0] idx_list [4];
        logic [7:0]           val_list [4];
        int                   k;
        idx_list = '{REG_START, REG_END, REG_REPLY, REG_UNUSED};
        val_list = '{s, e, r, 8'($urandom_range(0, 255))};
        pause_rx();
        for (k = 0; k < (junk ? 4 : 3); k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_list[k];
            i_cfg_data  <= val_list[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx_list[k])
                REG_START: cfg_start = val_list[k];
                REG_END:   cfg_end   = val_list[k];
                REG_REPLY: cfg_reply = val_list[k];
                default:   ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // mostly well formed frames with random content, mixed with broken frames and noise
    task automatic run_random(input int budget);
        int goal;
        int r;
        int dlen;
        goal = rx_sent + budget;
        while (rx_sent < goal) begin
            calm_gap = ($urandom_range(0, 6) == 0);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_rx(cfg_start);
                send_rx(($urandom_range(0, 9) != 0) ? CMD_TAG : 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 99) < 85) begin
                    // digits 00 to 04: unknown, led on, led off, dump, unknown
                    send_rx(ASCII_ZERO);
                    send_rx(ASCII_ZERO + 8'($urandom_range(0, 4)));
                end else begin
                    send_rx(8'($urandom_range(0, 255)));
                    send_rx(8'($urandom_range(0, 255)));
                end
                r = $urandom_range(0, 99);
                if (r < 60) dlen = $urandom_range(0, 4);
                else if (r < 85) dlen = $urandom_range(5, DATA_MAX_DEF - 1);
                else dlen = DATA_MAX_DEF;   // closing byte then hits the data limit
                repeat (dlen) send_rx(pick_payload_byte());
                send_rx(cfg_end);
            end else if (r < 85) begin
                send_rx(cfg_start);
                repeat ($urandom_range(0, 5)) send_rx(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) send_rx(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 11) == 0) pause_rx();
        end
    endtask

    // result side: random stalls, mostly short, with long ready stretches
    initial begin
        int r;
        forever begin
            r = $urandom_range(0, 99);
            if (r >= 50) begin
                i_ready <= 1'b0;
                if (r < 85) repeat ($urandom_range(1, 3)) @(posedge i_clk);
                else if (r < 97) repeat ($urandom_range(4, 10)) @(posedge i_clk);
                else repeat ($urandom_range(20, 40)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 60)) @(posedge i_clk);
            else repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // compare each accepted result with the oldest pending one
    always @(posedge i_clk) begin : result_check
        t_parser_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (parser_out_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got event %0d tx %0h",
                         $time, o_event_res, o_tx_byte);
                mismatch_cnt++;
            end else begin
                want = parser_out_q.pop_front();
                cmp_field("tx_byte", want.tx_byte, o_tx_byte);
                cmp_field("tx_valid", 8'(want.tx_valid), 8'(o_tx_valid));
                cmp_field("led_on", 8'(want.led_on), 8'(o_led_on));
                cmp_field("event_res", 8'(want.ev), 8'(o_event_res));
                cmp_field("last", 8'(want.last), 8'(o_last));
            end
        end
    end

    initial begin
        t_stim_row dir_tab [25];
        logic [7:0] same;
        int k;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_rx_byte   <= 8'h00;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_START;
        i_cfg_data  <= 8'h00;

        cfg_start = START_RST;
        cfg_end   = END_RST;
        cfg_reply = REPLY_RST;
        p_phase   = PH_IDLE;
        p_pos     = '0;
        p_led     = 1'b0;
        for (k = 0; k < CMD_LEN_DEF; k++) p_cmd[k] = 8'h00;
        for (k = 0; k < DATA_MAX_DEF; k++) p_data[k] = 8'h00;

        // reset registers: start 2, end 3, reply 0
        dir_tab = '{
            // bytes outside a frame are ignored
            '{8'h00,            1'b1, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{8'hFF,            1'b1, 8'h00, 1'b0, 1'b0, EV_NONE},
            // dump on an empty frame shows the cleared data store
            '{START_RST,        1'b1, 8'h00, 1'b0, 1'b0, EV_START},
            '{CMD_TAG,          1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{ASCII_ZERO,       1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{ASCII_ZERO + 8'd3, 1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{END_RST,          1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            // led on with data bytes at the extremes
            '{START_RST,        1'b1, 8'h00, 1'b0, 1'b0, EV_START},
            '{CMD_TAG,          1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{ASCII_ZERO,       1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{ASCII_ZERO + 8'd1, 1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{8'hFF,            1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{8'h00,            1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{8'hA5,            1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{END_RST,          1'b1, REPLY_RST, 1'b1, 1'b1, EV_DONE},
            // wrong tag drops the frame
            '{START_RST,        1'b1, 8'h00, 1'b0, 1'b1, EV_START},
            '{8'h58,            1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{ASCII_ZERO,       1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{ASCII_ZERO + 8'd2, 1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{END_RST,          1'b1, 8'h00, 1'b0, 1'b1, EV_REJECT},
            // led off
            '{START_RST,        1'b1, 8'h00, 1'b0, 1'b1, EV_START},
            '{CMD_TAG,          1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{ASCII_ZERO,       1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{ASCII_ZERO + 8'd2, 1'b0, 8'h00, 1'b0, 1'b0, EV_NONE},
            '{END_RST,          1'b1, 8'h00, 1'b0, 1'b0, EV_DONE}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < 25; k++)
            send_rx(dir_tab[k].rx, dir_tab[k].typed,
                    '{dir_tab[k].tx, dir_tab[k].txv, dir_tab[k].led, dir_tab[k].ev, 1'b1});

        // register extremes, start equal to end, random values, default start and end bytes
        program_cfg(8'h00, 8'hFF, 8'hFF, 1'b0);
        run_random(35);
        program_cfg(8'hFF, 8'h00, 8'h00, 1'b1);
        run_random(35);
        same = 8'($urandom_range(0, 255));
        program_cfg(same, same, 8'($urandom_range(0, 255)), 1'b0);
        run_random(35);
        program_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'b1);
        run_random(35);
        program_cfg(START_RST, END_RST, 8'($urandom_range(0, 255)), 1'b0);
        run_random(35);

        // drain, then leave room for any stray result
        pause_rx();
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("tb_stx_etx_command_frame_parser_top: clean");
        else
            $display("tb_stx_etx_command_frame_parser_top: errors");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("tb_stx_etx_command_frame_parser_top: errors");
        $finish;
    end

endmodule
